// ===== rtl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Types and constants for the radix digit converter: controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int DIGIT_W = 8;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 8'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 8'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_POP,
        S_DATA
    } t_state;

    typedef struct packed {
        logic load;      // take a new value, clear digit count
        logic start;     // clear remainder and step counter
        logic div_step;  // one restoring division step
        logic push;      // write remainder onto digit stack
        logic pop;       // read top of digit stack
        logic out_load;  // load output register from stack read data
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic count_zero;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/rdc_ram.sv =====
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rdc_datapath.sv =====
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix register, bit-serial restoring divider, digit stack and output
// register of the radix digit converter.
// ----------------------------------------------------------------------------
module rdc_datapath #(
    parameter int VALUE_WIDTH = 31,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_data,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  rdc_pkg::t_cmd          i_cmd,
    output rdc_pkg::t_status       o_status,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [7:0]             o_m_digit,
    output logic                   o_m_last
);

    import rdc_pkg::*;

    localparam int STEP_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);

    logic [DIGIT_W-1:0]     r_radix;
    logic [VALUE_WIDTH-1:0] r_quot;
    logic [DIGIT_W-1:0]     r_rem;
    logic [STEP_W-1:0]      r_step;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_valid;
    logic [DIGIT_W-1:0]     r_out_digit;
    logic                   r_out_last;

    logic [DIGIT_W-1:0]     base;
    logic [DIGIT_W:0]       trial;
    logic                   ge;
    logic [DIGIT_W:0]       diff;
    logic                   full;
    logic                   we;
    logic [CNT_W-1:0]       count_dec;
    logic [DIGIT_W-1:0]     rd_data;

    assign base  = (r_radix < RADIX_MIN) ? RADIX_MIN : r_radix;
    assign trial = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign ge    = trial >= {1'b0, base};
    assign diff  = trial - {1'b0, base};

    assign full      = r_count == CNT_W'(MAX_DIGITS);
    assign we        = i_cmd.push && !full;
    assign count_dec = r_count - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.load) begin
                r_quot  <= i_value;
                r_count <= '0;
            end else begin
                if (i_cmd.div_step) begin
                    r_quot <= {r_quot[VALUE_WIDTH-2:0], ge};
                end
                if (we) begin
                    r_count <= r_count + 1'b1;
                end else if (i_cmd.pop) begin
                    r_count <= count_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_rem),
        .i_re    (i_cmd.pop),
        .i_raddr (count_dec[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_digit <= rd_data;
            r_out_last  <= r_count == '0;
        end
    end

    assign o_status.div_last   = r_step == STEP_W'(VALUE_WIDTH - 1);
    assign o_status.quot_zero  = r_quot == '0;
    assign o_status.count_zero = r_count == '0;
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_digit  = r_out_digit;
    assign o_m_last   = r_out_last;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten while a result waits");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0)
        else $error("pop from empty digit stack");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && !i_cmd.load) |=> r_count == $past(r_count) + 1'b1)
        else $error("digit count did not advance on push");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond stack depth");

endmodule

// ===== rtl/rdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdc_ctrl
// Controller of the radix digit converter: sequences division steps,
// stack pushes and pops, and result hand-off.
// ----------------------------------------------------------------------------
module rdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  rdc_pkg::t_status i_status,
    output rdc_pkg::t_cmd    o_cmd
);

    import rdc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_status.quot_zero) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_DATA;
            end
            S_DATA: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = i_status.count_zero ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a non-negative integer to digits of a configured radix, most
// significant first, with tlast on the final digit. Zero gives one digit 0.
// ----------------------------------------------------------------------------
// The value is divided by the radix once per digit in a restoring divider
//   that produces one quotient bit per cycle; remainders go onto the stack.
// Digits leave through a stack RAM read, then the output register, which
//   holds while the output stalls. A new value is taken only in idle.
// Reset (synchronous, active low) returns to idle, radix 2, empty stack.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
    parameter int VALUE_WIDTH = 31,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [7:0]                           i_cfg_data,     // radix
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata, // value
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [7:0]                           o_m_axis_tdata, // digit
    output logic                                 o_m_axis_tlast  // last_digit
);

    import rdc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rdc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_value    (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_digit  (o_m_axis_tdata),
        .o_m_last   (o_m_axis_tlast)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radix_digit_converter. Values go in on the slave
// stream, the bench works out the digit sequence for the current radix and
// checks every digit and its tlast on the master stream in order. Covers
// zero, full-range values, radix extremes including 0 and 1, random traffic
// with bursty input and stalling output, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import rdc_pkg::*;

    localparam int VALUE_W      = 31;
    localparam int DATA_W       = ((VALUE_W + 7) / 8) * 8;
    localparam int STACK_DEPTH  = 32;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 4000;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_ITEMS  = 25;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               is_last;
    } t_digit_rec;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [7:0]         cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic [DATA_W-1:0]  s_tdata   = '0;
    logic               m_tready  = 1'b0;

    logic               o_cfg_ready;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [7:0]         o_m_axis_tdata;
    logic               o_m_axis_tlast;

    logic [VALUE_W-1:0] value_q[$];
    t_digit_rec         pending_digits[$];
    logic [7:0]         radix_now = RADIX_RESET;
    int                 items_queued   = 0;
    int                 items_accepted = 0;
    int                 error_count    = 0;
    int                 cycle_count    = 0;
    int                 quiet_cycles   = 0;
    int                 burst_left     = 1;
    int                 gap_left       = 0;
    int                 hold_left      = 0;
    logic               hold_done      = 1'b0;
    int                 rx_tick        = 0;
    t_rx_mode           rx_mode        = RX_OPEN;

    radix_digit_converter #(
        .VALUE_WIDTH (VALUE_W),
        .MAX_DIGITS  (STACK_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // remainders stacked LSD first, then unstacked MSD first
    function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                           input logic [7:0] radix);
        logic [DIGIT_W-1:0] rem_stack[STACK_DEPTH];
        logic [VALUE_W-1:0] quot;
        logic [7:0]         base;
        t_digit_rec         rec;
        int                 depth;
        base  = (radix < RADIX_MIN) ? RADIX_MIN : radix;
        quot  = value;
        depth = 0;
        if (quot == '0) begin
            rem_stack[0] = '0;
            depth = 1;
        end
        while (quot != '0) begin
            if (depth < STACK_DEPTH) begin
                rem_stack[depth] = DIGIT_W'(quot % base);
                depth++;
            end
            quot = quot / base;
        end
        for (int i = depth - 1; i >= 0; i--) begin
            rec.digit   = rem_stack[i];
            rec.is_last = (i == 0);
            pending_digits.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 30)
            $display("tb_top: %s mismatch, got %0d want %0d, cycle %0d",
                     what, got, want, cycle_count);
    endtask

    // sender: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid       <= 1'b0;
            items_accepted <= 0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                predict_digits(s_tdata[VALUE_W-1:0], radix_now);
                items_accepted <= items_accepted + 1;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (value_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= DATA_W'(value_q.pop_front());
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(0, 1100);
                            default: gap_left = $urandom_range(0, 40);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern re-drawn whenever the low seven bits of rx_tick are zero, one long hold-off
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (rx_tick[6:0] == 7'd0)
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && items_accepted >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
                    RX_SPARSE: m_tready <= (rx_tick[1:0] == 2'd0);
                    default:   m_tready <= (rx_tick[4:0] > 5'd20);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : digit_check
        t_digit_rec due;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_digits.size() == 0) begin
                report_mismatch("unexpected digit", o_m_axis_tdata, -1);
            end else begin
                due = pending_digits.pop_front();
                if (o_m_axis_tdata !== due.digit)
                    report_mismatch("digit", o_m_axis_tdata, due.digit);
                if (o_m_axis_tlast !== due.is_last)
                    report_mismatch("tlast", o_m_axis_tlast, due.is_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_value(input logic [VALUE_W-1:0] v);
        value_q.push_back(v);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || pending_digits.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [7:0] r);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        cfg_valid <= 1'b0;
        radix_now = r;
    endtask

    function automatic logic [7:0] pick_radix();
        case ($urandom_range(0, 7))
            0:       return 8'd2;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 1));
            3:       return 8'd10;
            4:       return 8'd16;
            default: return 8'($urandom_range(2, 255));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input logic [7:0] radix);
        longint pow;
        longint base;
        int     span;
        int     k;
        base = (radix < 2) ? 2 : radix;
        case ($urandom_range(0, 5))
            0, 1: return VALUE_W'($urandom());
            2: begin
                span = $urandom_range(1, VALUE_W);
                return VALUE_W'($urandom()) & VALUE_W'((64'd1 << span) - 1);
            end
            3: return VALUE_W'($urandom_range(0, 300));
            4: begin
                // near a power of the radix, where the digit count steps
                pow = 1;
                k = $urandom_range(0, VALUE_W);
                for (int i = 0; i < k; i++)
                    if (pow * base <= longint'(VALUE_MAX))
                        pow = pow * base;
                pow = pow + $urandom_range(0, 2) - 1;
                if (pow > longint'(VALUE_MAX))
                    pow = longint'(VALUE_MAX);
                return VALUE_W'(pow);
            end
            default: return $urandom_range(0, 1) ? VALUE_MAX : '0;
        endcase
    endfunction

    initial begin
        logic [7:0] r;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        // reset radix, binary extremes
        queue_value('0);
        queue_value(VALUE_W'(1));
        queue_value(VALUE_MAX);
        queue_value(VALUE_W'(32'h4000_0000));
        queue_value(VALUE_W'(32'h2AAA_AAAA));
        queue_value(VALUE_W'(32'h5555_5555));
        wait_drained();

        write_radix(8'd10);
        queue_value('0);
        queue_value(VALUE_W'(9));
        queue_value(VALUE_W'(10));
        queue_value(VALUE_W'(1000000000));
        queue_value(VALUE_MAX);
        wait_drained();

        write_radix(8'd255);
        queue_value(VALUE_W'(254));
        queue_value(VALUE_W'(255));
        queue_value(VALUE_W'(65025));
        queue_value(VALUE_MAX);
        wait_drained();

        // radix below two saturates to binary
        write_radix(8'd0);
        queue_value(VALUE_W'(5));
        queue_value('0);
        wait_drained();
        write_radix(8'd1);
        queue_value(VALUE_W'(6));
        wait_drained();

        write_radix(8'd16);
        queue_value(VALUE_MAX);
        queue_value(VALUE_W'(32'h1234_5678));
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            r = pick_radix();
            write_radix(r);
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_value(pick_value(r));
            wait_drained();
        end

        repeat (64) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rdc_pkg.sv
rtl/rdc_ram.sv
rtl/rdc_datapath.sv
rtl/rdc_ctrl.sv
rtl/radix_digit_converter.sv
verif/tb_top.sv
